[sv/cpsb_pkg.sv]
// Shared types, constants and defaults for the cell pack statistics and balance mask block.
`default_nettype none

package cpsb_pkg;

  localparam int CELLS           = 6;
  localparam int CELL_W          = 16;
  localparam int ADDR_W          = 6;
  localparam int SUM_W           = 23;
  localparam int ITEM_SUM_W      = CELL_W + 3;
  localparam int DELTA_W         = 17;
  localparam int COUNT_W         = 7;
  localparam int DUTY_W          = 6;
  localparam int ROW_W           = CELLS * CELL_W + ADDR_W;
  localparam int IN_TDATA_W      = 104;
  localparam int OUT_TDATA_W     = 104;
  localparam int PADDR_W         = 5;
  localparam int PDATA_W         = 32;
  localparam int DEFAULT_MODULES = 16;

  localparam logic [CELL_W-1:0]  LOW_START = 16'd13107;
  localparam logic [DUTY_W-1:0]  DUTY_ON   = 6'd50;
  localparam logic [SUM_W-1:0]   SUM_MAX   = 23'h7FFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  localparam logic [CELL_W-1:0] RST_START_CODE = 16'd10747;
  localparam logic [CELL_W-1:0] RST_DELTA_MIN  = 16'd104;
  localparam logic [CELL_W-1:0] RST_LOW_MIN    = 16'd1311;
  localparam logic [CELL_W-1:0] RST_HIGH_MAX   = 16'd11795;

  localparam logic [2:0] REG_BAL_EN   = 3'd0;
  localparam logic [2:0] REG_START    = 3'd1;
  localparam logic [2:0] REG_DELTA    = 3'd2;
  localparam logic [2:0] REG_LOW_MIN  = 3'd3;
  localparam logic [2:0] REG_HIGH_MAX = 3'd4;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_STATS,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

[sv/cpsb_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read and read enable.
`default_nettype none

module cpsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/cell_pack_stats_balance_mask.sv]
// Top level of the cell pack statistics and balance mask block.
//
// The in_ channel takes one word per battery module: six 16-bit cell codes
// and the module address in tdata, with tlast marking the final module of a
// sweep. Each accepted word is registered, then in the next cycle its cells
// are written as one row of the cell RAM while the pack sum, low cell and
// high cell accumulators are updated, so the block takes one word a cycle.
// After the final word, in_tready drops; the pack statistics settle in
// ST_STATS, then the RAM is read one row a cycle and one out_ word per
// stored module follows, in arrival order, with out_tlast on the last one.
// The first result comes through a RAM read into the result register.
// The result register holds its word while out_tready is low; the RAM read
// is then held, and the walk resumes when the word is taken. Once the last
// result is loaded the accumulators are clear and input is taken again.
// Modules beyond MODULES are not stored, but their tlast still ends the sweep.
// Reset (synchronous, rst_n low) restores the configuration defaults and
// clears the sweep; the RAM is not cleared and needs no clearing pass.
// Registers lie on the APB port at byte addresses 0, 4, 8, 12 and 16.
`default_nettype none

module cell_pack_stats_balance_mask #(
  parameter int MODULES = cpsb_pkg::DEFAULT_MODULES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // cell_a, cell_b, cell_c, cell_d, cell_e, cell_f, module_addr, zero pad
  input  wire logic [cpsb_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_module_addr, balance_mask, balance_duty, pack_sum, low_cell,
  // high_cell, cell_delta, cell_count, balancing_active, zero pad
  output logic      [cpsb_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                                  out_tlast,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cpsb_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [cpsb_pkg::PDATA_W-1:0]     pwdata,
  output logic      [cpsb_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready
);

  import cpsb_pkg::*;

  localparam int AW   = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int CW   = $clog2(MODULES + 1);
  localparam int CNTW = (CW + 3 > COUNT_W) ? CW + 3 : COUNT_W;

  // Configuration registers.
  logic              bal_en_r;
  logic [CELL_W-1:0] start_code_r;
  logic [CELL_W-1:0] delta_min_r;
  logic [CELL_W-1:0] low_min_r;
  logic [CELL_W-1:0] high_max_r;
  logic              cfg_wr;
  logic [2:0]        reg_idx;

  // Input stage.
  logic             s_valid_r;
  logic             s_last_r;
  logic [ROW_W-1:0] s_row_r;

  // Accumulators and control.
  state_t            state_r, state_nxt;
  logic [CW-1:0]     seen_r, seen_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CELL_W-1:0] low_r, low_nxt;
  logic [CELL_W-1:0] high_r, high_nxt;
  logic [CW-1:0]     emit_k_r, emit_k_nxt;
  logic [CW-1:0]     lidx_r;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Sweep statistics held during the walk.
  logic [CW-1:0]      st_n_r;
  logic [SUM_W-1:0]   st_sum_r;
  logic [CELL_W-1:0]  st_low_r;
  logic [CELL_W-1:0]  st_high_r;
  logic [DELTA_W-1:0] st_delta_r;
  logic [COUNT_W-1:0] st_count_r;
  logic               st_active_r;

  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  logic                  store;
  logic                  out_free;
  logic                  rd_issue;
  logic                  load_out;
  logic                  last_idx;
  logic [ITEM_SUM_W-1:0] item_sum;
  logic [CELL_W-1:0]     item_lo;
  logic [CELL_W-1:0]     item_hi;
  logic [CELL_W-1:0]     c;
  logic [SUM_W:0]        sum_ext;
  logic [DELTA_W-1:0]    delta;
  logic                  active;
  logic [CNTW-1:0]       cnt_full;
  logic [COUNT_W-1:0]    count;
  logic [ROW_W-1:0]      ram_rdata;
  logic [CELLS-1:0]      mask;

  // APB register file.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bal_en_r     <= 1'b0;
      start_code_r <= RST_START_CODE;
      delta_min_r  <= RST_DELTA_MIN;
      low_min_r    <= RST_LOW_MIN;
      high_max_r   <= RST_HIGH_MAX;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BAL_EN:   bal_en_r     <= pwdata[0];
        REG_START:    start_code_r <= pwdata[CELL_W-1:0];
        REG_DELTA:    delta_min_r  <= pwdata[CELL_W-1:0];
        REG_LOW_MIN:  low_min_r    <= pwdata[CELL_W-1:0];
        REG_HIGH_MAX: high_max_r   <= pwdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BAL_EN:   prdata = {{(PDATA_W-1){1'b0}}, bal_en_r};
      REG_START:    prdata = {{(PDATA_W-CELL_W){1'b0}}, start_code_r};
      REG_DELTA:    prdata = {{(PDATA_W-CELL_W){1'b0}}, delta_min_r};
      REG_LOW_MIN:  prdata = {{(PDATA_W-CELL_W){1'b0}}, low_min_r};
      REG_HIGH_MAX: prdata = {{(PDATA_W-CELL_W){1'b0}}, high_max_r};
      default:      prdata = '0;
    endcase
  end

  // Input stage.
  assign in_tready = (state_r == ST_ACC) && !(s_valid_r && s_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      s_last_r  <= 1'b0;
    end else begin
      s_valid_r <= in_tvalid && in_tready;
      s_last_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_row_r <= in_tdata[ROW_W-1:0];
    end
  end

  // Six-cell reduction against the running accumulators.
  always_comb begin
    item_sum = '0;
    item_lo  = low_r;
    item_hi  = high_r;
    c        = '0;
    for (int i = 0; i < CELLS; i++) begin
      c        = s_row_r[i*CELL_W +: CELL_W];
      item_sum = item_sum + ITEM_SUM_W'(c);
      if (c >= low_min_r && c < item_lo) begin
        item_lo = c;
      end
      if (c <= high_max_r && c > item_hi) begin
        item_hi = c;
      end
    end
  end

  assign sum_ext = {1'b0, sum_r} + (SUM_W+1)'(item_sum);
  assign store   = s_valid_r && (seen_r < CW'(MODULES));

  // Pack statistics from the settled accumulators.
  assign delta    = {1'b0, high_r} - {1'b0, low_r};
  assign active   = bal_en_r && (high_r > start_code_r) &&
                    ($signed(delta) > $signed({1'b0, delta_min_r}));
  assign cnt_full = CNTW'({seen_r, 2'b00}) + CNTW'({seen_r, 1'b0});
  assign count    = (cnt_full > CNTW'(COUNT_MAX)) ? COUNT_MAX : cnt_full[COUNT_W-1:0];

  // Result walk.
  assign out_free = !out_valid_r || out_tready;
  assign rd_issue = (state_r == ST_EMIT) && (emit_k_r < st_n_r) && (!pend_r || out_free);
  assign load_out = pend_r && out_free;
  assign last_idx = (lidx_r == st_n_r - CW'(1));

  cpsb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MODULES),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (store),
    .waddr (seen_r[AW-1:0]),
    .wdata (s_row_r),
    .re    (rd_issue),
    .raddr (emit_k_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    sum_nxt       = sum_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    emit_k_nxt    = emit_k_r;
    pend_nxt      = rd_issue || (pend_r && !out_free);
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_ACC: begin
        if (store) begin
          seen_nxt = seen_r + CW'(1);
          sum_nxt  = (sum_ext > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
          low_nxt  = item_lo;
          high_nxt = item_hi;
        end
        if (s_valid_r && s_last_r) begin
          state_nxt = ST_STATS;
        end
      end
      ST_STATS: begin
        seen_nxt   = '0;
        sum_nxt    = '0;
        low_nxt    = LOW_START;
        high_nxt   = '0;
        emit_k_nxt = '0;
        state_nxt  = (seen_r == '0) ? ST_ACC : ST_EMIT;
      end
      ST_EMIT: begin
        if (rd_issue) begin
          emit_k_nxt = emit_k_r + CW'(1);
        end
        if (load_out && last_idx) begin
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      seen_r      <= '0;
      sum_r       <= '0;
      low_r       <= LOW_START;
      high_r      <= '0;
      emit_k_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      sum_r       <= sum_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      emit_k_r    <= emit_k_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_STATS) begin
      st_n_r      <= seen_r;
      st_sum_r    <= sum_r;
      st_low_r    <= low_r;
      st_high_r   <= high_r;
      st_delta_r  <= delta;
      st_count_r  <= count;
      st_active_r <= active;
    end
    if (rd_issue) begin
      lidx_r <= emit_k_r;
    end
    if (load_out) begin
      out_data_r <= {{(OUT_TDATA_W-98){1'b0}}, st_active_r, st_count_r, st_delta_r,
                     st_high_r, st_low_r, st_sum_r,
                     st_active_r ? DUTY_ON : {DUTY_W{1'b0}},
                     mask, ram_rdata[ROW_W-1 -: ADDR_W]};
      out_last_r <= last_idx;
    end
  end

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      mask[i] = st_active_r && (ram_rdata[i*CELL_W +: CELL_W] > st_low_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The held RAM word must not change while a read result waits on a stall.
  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !out_free) |=> $stable(ram_rdata))
    else $error("RAM read data changed while the result register was stalled");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CW'(MODULES))
    else $error("module count exceeded the store depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (emit_k_r <= st_n_r))
    else $error("result walk ran past the stored modules");

  a_no_input_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && s_last_r) |-> !(in_tvalid && in_tready))
    else $error("input word taken behind the final word of a sweep");

endmodule

`default_nettype wire
